/* hdl/rma_pkg.sv */
// shared types, codes and helpers for the region map allocator checker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rma_pkg;

   localparam int MAX_REGIONS_DEF = 32;
   localparam int PAGE_BYTES_DEF  = 4096;
   localparam logic [31:0] CURSOR_RESET = 32'h1000_0000;

   typedef enum logic [2:0] {
      MODE_MAP     = 3'd0,
      MODE_ALLOC   = 3'd1,
      MODE_PROTECT = 3'd2,
      MODE_FREE    = 3'd3,
      MODE_QUERY   = 3'd4,
      MODE_RDCHK   = 3'd5,
      MODE_WRCHK   = 3'd6
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_INVALID   = 3'd1,
      ST_LIMIT     = 3'd2,
      ST_CONFLICT  = 3'd3,
      ST_VIOLATION = 3'd4,
      ST_NOT_FOUND = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_READ,
      S_EVAL,
      S_PLACE,
      S_APPEND,
      S_UPDATE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [31:0] base;
      logic [31:0] length;
      logic [7:0]  prot;
   } entry_type;

   // compare unit results for one table entry
   typedef struct packed {
      logic        overlap;
      logic        holds;
      logic        base_eq;
      logic [31:0] end_round;
   } cmp_type;

   function automatic logic [31:0] round_up(input logic [31:0] v, input logic [31:0] mask);
      round_up = (v + mask) & ~mask;
   endfunction

endpackage
`default_nettype wire

/* hdl/rma_ram.sv */
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module rma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

/* hdl/rma_cmp.sv */
// shared range compare unit: overlap, containment, base match, rounded end
// depends on rma_pkg
`timescale 1ns / 1ps
`default_nettype none
module rma_cmp
   import rma_pkg::*;
#(
   parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
   input  wire logic [31:0] op_start,
   input  wire logic [31:0] op_len,
   input  wire entry_type   entry,
   output cmp_type          result
);

   localparam logic [31:0] PAGE_MASK = 32'(PAGE_BYTES - 1);

   logic [32:0] op_end;
   logic [32:0] ent_end;

   always_comb begin
      op_end  = {1'b0, op_start} + {1'b0, op_len};
      ent_end = {1'b0, entry.base} + {1'b0, entry.length};
      result.overlap   = ({1'b0, op_start} < ent_end) && ({1'b0, entry.base} < op_end);
      result.holds     = (op_start >= entry.base) && (op_end <= ent_end);
      result.base_eq   = (op_start == entry.base);
      result.end_round = round_up(ent_end[31:0], PAGE_MASK);
   end

endmodule
`default_nettype wire

/* hdl/region_map_allocator_checker_unit.sv */
// region map allocator checker top level: sequencer, table ram, compare unit
// depends on rma_pkg, rma_ram, rma_cmp
// flow: decode, then a read and an evaluate step per table entry visited, then respond
// map, protect, query and checks walk at most count entries; free adds a read and a write per moved entry
// allocate may rescan: up to (count+1) passes of at most count entries each
// one request at a time; reset empties the table and sets the cursor to 0x10000000
`timescale 1ns / 1ps
`default_nettype none
module region_map_allocator_checker_unit
   import rma_pkg::*;
#(
   parameter int MAX_REGIONS = MAX_REGIONS_DEF,
   parameter int PAGE_BYTES  = PAGE_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_mode,
   input  wire logic [31:0] req_address,
   input  wire logic [31:0] req_size,
   input  wire logic [7:0]  req_protection,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_base_out,
   output logic [7:0]       rsp_protection_out,
   output logic [31:0]      rsp_remaining_bytes,
   output logic [4:0]       rsp_region_slot,
   output logic [31:0]      rsp_region_offset
);

   localparam int SW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CW = $clog2(MAX_REGIONS + 1);
   localparam logic [31:0] PAGE_MASK = 32'(PAGE_BYTES - 1);

   // sequencer state
   state_type state_ff, state_in;

   // latched request
   logic [2:0]  mode_ff, mode_in;
   logic [31:0] addr_ff, addr_in;
   logic [31:0] size_ff, size_in;
   logic [7:0]  prot_ff, prot_in;

   // operand range fed to the compare unit
   logic [31:0] opa_ff, opa_in;
   logic [31:0] opl_ff, opl_in;

   // walk position and allocate pass count
   logic [SW-1:0] idx_ff, idx_in;
   logic [CW-1:0] attempt_ff, attempt_in;

   // table control state
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   cursor_ff, cursor_in;

   // entry being rewritten by protect
   entry_type ent_ff, ent_in;

   // result registers
   logic [2:0]  status_ff, status_in;
   logic [31:0] base_out_ff, base_out_in;
   logic [7:0]  prot_out_ff, prot_out_in;
   logic [31:0] remain_ff, remain_in;
   logic [4:0]  slot_ff, slot_in;
   logic [31:0] offset_ff, offset_in;

   // ram ports
   logic          ram_we;
   logic [SW-1:0] ram_waddr;
   entry_type     ram_wdata;
   logic [SW-1:0] ram_raddr;
   entry_type     ram_rdata;

   cmp_type cmp;

   logic [31:0] len_rnd;
   logic [32:0] map_end;
   logic [32:0] place_end;
   logic        full;
   logic        last;
   logic        cnt_zero;
   logic        shift_last;

   rma_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_REGIONS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   rma_cmp #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_cmp (
      .op_start (opa_ff),
      .op_len   (opl_ff),
      .entry    (ram_rdata),
      .result   (cmp)
   );

   // shared decode helpers
   always_comb begin
      len_rnd    = round_up(size_ff, PAGE_MASK);
      map_end    = {1'b0, addr_ff} + {1'b0, len_rnd};
      place_end  = {1'b0, opa_ff} + {1'b0, opl_ff};
      full       = (count_ff >= CW'(MAX_REGIONS));
      cnt_zero   = (count_ff == '0);
      last       = (CW'(idx_ff) == (count_ff - 1'b1));
      shift_last = ((CW'(idx_ff) + 1'b1) == (count_ff - 1'b1));
   end

   // next state and datapath
   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      addr_in     = addr_ff;
      size_in     = size_ff;
      prot_in     = prot_ff;
      opa_in      = opa_ff;
      opl_in      = opl_ff;
      idx_in      = idx_ff;
      attempt_in  = attempt_ff;
      count_in    = count_ff;
      cursor_in   = cursor_ff;
      ent_in      = ent_ff;
      status_in   = status_ff;
      base_out_in = base_out_ff;
      prot_out_in = prot_out_ff;
      remain_in   = remain_ff;
      slot_in     = slot_ff;
      offset_in   = offset_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               addr_in  = req_address;
               size_in  = req_size;
               prot_in  = req_protection;
               state_in = S_CHECK;
            end
         end

         S_CHECK: begin
            status_in   = ST_OK;
            base_out_in = '0;
            prot_out_in = '0;
            remain_in   = '0;
            slot_in     = '0;
            offset_in   = '0;
            idx_in      = '0;
            attempt_in  = '0;
            opa_in      = addr_ff;
            opl_in      = size_ff;
            state_in    = S_READ;
            case (mode_ff)
               MODE_MAP: begin
                  opl_in = len_rnd;
                  if (size_ff == '0 || (addr_ff & PAGE_MASK) != '0) begin
                     status_in = ST_INVALID;
                     state_in  = S_DONE;
                  end else if (len_rnd == '0 || map_end[32] || full) begin
                     status_in = ST_LIMIT;
                     state_in  = S_DONE;
                  end else if (cnt_zero) begin
                     state_in = S_APPEND;
                  end
               end
               MODE_ALLOC: begin
                  opl_in = len_rnd;
                  opa_in = round_up(cursor_ff, PAGE_MASK);
                  if (size_ff == '0) begin
                     status_in = ST_INVALID;
                     state_in  = S_DONE;
                  end else if (len_rnd == '0) begin
                     status_in = ST_LIMIT;
                     state_in  = S_DONE;
                  end else if (cnt_zero) begin
                     state_in = S_PLACE;
                  end
               end
               MODE_PROTECT: begin
                  if (size_ff == '0) begin
                     status_in = ST_INVALID;
                     state_in  = S_DONE;
                  end else if (cnt_zero) begin
                     status_in = ST_VIOLATION;
                     state_in  = S_DONE;
                  end
               end
               MODE_FREE: begin
                  if (addr_ff == '0) begin
                     status_in = ST_INVALID;
                     state_in  = S_DONE;
                  end else if (cnt_zero) begin
                     status_in = ST_NOT_FOUND;
                     state_in  = S_DONE;
                  end
               end
               MODE_QUERY: begin
                  opl_in = 32'd1;
                  if (cnt_zero) begin
                     status_in = ST_NOT_FOUND;
                     state_in  = S_DONE;
                  end
               end
               MODE_RDCHK, MODE_WRCHK: begin
                  if (size_ff == '0) begin
                     state_in = S_DONE;
                  end else if (cnt_zero) begin
                     status_in = ST_VIOLATION;
                     state_in  = S_DONE;
                  end
               end
               default: begin
                  status_in = ST_INVALID;
                  state_in  = S_DONE;
               end
            endcase
         end

         // ram address is presented here, data arrives for eval
         S_READ: begin
            state_in = S_EVAL;
         end

         S_EVAL: begin
            state_in = S_READ;
            idx_in   = idx_ff + 1'b1;
            case (mode_ff)
               MODE_MAP: begin
                  if (cmp.overlap) begin
                     status_in = ST_CONFLICT;
                     state_in  = S_DONE;
                  end else if (last) begin
                     state_in = S_APPEND;
                  end
               end
               MODE_ALLOC: begin
                  if (cmp.overlap) begin
                     // push candidate past the blocking region and rescan
                     opa_in = cmp.end_round;
                     idx_in = '0;
                     if (attempt_ff == count_ff) begin
                        status_in = ST_CONFLICT;
                        state_in  = S_DONE;
                     end else begin
                        attempt_in = attempt_ff + 1'b1;
                     end
                  end else if (last) begin
                     state_in = S_PLACE;
                  end
               end
               MODE_PROTECT: begin
                  if (cmp.holds) begin
                     ent_in      = ram_rdata;
                     ent_in.prot = prot_ff;
                     idx_in      = idx_ff;
                     state_in    = S_UPDATE;
                  end else if (last) begin
                     status_in = ST_VIOLATION;
                     state_in  = S_DONE;
                  end
               end
               MODE_FREE: begin
                  if (cmp.base_eq) begin
                     idx_in = idx_ff;
                     if (last) begin
                        count_in = count_ff - 1'b1;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_SHIFT_RD;
                     end
                  end else if (last) begin
                     status_in = ST_NOT_FOUND;
                     state_in  = S_DONE;
                  end
               end
               MODE_QUERY: begin
                  if (cmp.holds) begin
                     prot_out_in = ram_rdata.prot;
                     remain_in   = ram_rdata.length - (addr_ff - ram_rdata.base);
                     state_in    = S_DONE;
                  end else if (last) begin
                     status_in = ST_NOT_FOUND;
                     state_in  = S_DONE;
                  end
               end
               MODE_RDCHK, MODE_WRCHK: begin
                  if (cmp.holds) begin
                     state_in = S_DONE;
                     if ((mode_ff == MODE_RDCHK && !ram_rdata.prot[0]) ||
                         (mode_ff == MODE_WRCHK && !ram_rdata.prot[1])) begin
                        status_in = ST_VIOLATION;
                     end else begin
                        slot_in   = 5'(idx_ff);
                        offset_in = addr_ff - ram_rdata.base;
                     end
                  end else if (last) begin
                     status_in = ST_VIOLATION;
                     state_in  = S_DONE;
                  end
               end
               default: begin
                  status_in = ST_INVALID;
                  state_in  = S_DONE;
               end
            endcase
         end

         // allocate found a free gap: apply the map limit checks
         S_PLACE: begin
            if (place_end[32] || full) begin
               status_in = ST_LIMIT;
               state_in  = S_DONE;
            end else begin
               state_in = S_APPEND;
            end
         end

         S_APPEND: begin
            count_in = count_ff + 1'b1;
            if (opa_ff >= cursor_ff) begin
               cursor_in = opa_ff + opl_ff;
            end
            if (mode_ff == MODE_ALLOC) begin
               base_out_in = opa_ff;
            end
            state_in = S_DONE;
         end

         S_UPDATE: begin
            state_in = S_DONE;
         end

         // compaction after free: slot idx takes slot idx+1
         S_SHIFT_RD: begin
            state_in = S_SHIFT_WR;
         end

         S_SHIFT_WR: begin
            idx_in = idx_ff + 1'b1;
            if (shift_last) begin
               count_in = count_ff - 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_SHIFT_RD;
            end
         end

         S_DONE: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // handshake and table port controls
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = idx_ff;
      ram_wdata = ram_rdata;
      ram_raddr = idx_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
         end
         S_APPEND: begin
            ram_we    = 1'b1;
            ram_waddr = count_ff[SW-1:0];
            ram_wdata = '{base: opa_ff, length: opl_ff, prot: prot_ff};
         end
         S_UPDATE: begin
            ram_we    = 1'b1;
            ram_wdata = ent_ff;
         end
         S_SHIFT_RD: begin
            ram_raddr = idx_ff + 1'b1;
         end
         S_SHIFT_WR: begin
            ram_we = 1'b1;
         end
         S_DONE: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         cursor_ff <= CURSOR_RESET;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      addr_ff     <= addr_in;
      size_ff     <= size_in;
      prot_ff     <= prot_in;
      opa_ff      <= opa_in;
      opl_ff      <= opl_in;
      idx_ff      <= idx_in;
      attempt_ff  <= attempt_in;
      ent_ff      <= ent_in;
      status_ff   <= status_in;
      base_out_ff <= base_out_in;
      prot_out_ff <= prot_out_in;
      remain_ff   <= remain_in;
      slot_ff     <= slot_in;
      offset_ff   <= offset_in;
   end

   assign rsp_status          = status_ff;
   assign rsp_base_out        = base_out_ff;
   assign rsp_protection_out  = prot_out_ff;
   assign rsp_remaining_bytes = remain_ff;
   assign rsp_region_slot     = slot_ff;
   assign rsp_region_offset   = offset_ff;

endmodule
`default_nettype wire
